// ===== src/aqbs_pkg.sv =====
`default_nettype none

package aqbs_pkg;

   localparam int QUADLET_W = 32;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int RING_LEN  = 15;

   localparam logic [NIB_W-1:0] HIGH_NINE   = 4'h9;
   localparam logic [NIB_W-1:0] OFFSET_SAT  = 4'd15;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [NIB_W-1:0]  nib_type;

   // Run length for each low nibble of the run index
   function automatic nib_type run_len_f(input nib_type lo);
      nib_type r;
      case (lo)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd1;
         4'd2:    r = 4'd3;
         4'd3:    r = 4'd5;
         4'd4:    r = 4'd7;
         4'd5:    r = 4'd9;
         4'd6:    r = 4'd11;
         4'd7:    r = 4'd13;
         4'd8:    r = 4'd14;
         4'd9:    r = 4'd12;
         4'd10:   r = 4'd10;
         4'd11:   r = 4'd8;
         4'd12:   r = 4'd6;
         4'd13:   r = 4'd4;
         4'd14:   r = 4'd2;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // Low salt nibble, indexed by position within the run
   function automatic nib_type low_nib_f(input nib_type i);
      nib_type r;
      case (i)
         4'd0:    r = 4'h8;
         4'd1:    r = 4'h7;
         4'd2:    r = 4'h9;
         4'd3:    r = 4'h6;
         4'd4:    r = 4'ha;
         4'd5:    r = 4'h5;
         4'd6:    r = 4'hb;
         4'd7:    r = 4'h4;
         4'd8:    r = 4'hc;
         4'd9:    r = 4'h3;
         4'd10:   r = 4'hd;
         4'd11:   r = 4'h2;
         4'd12:   r = 4'he;
         4'd13:   r = 4'h1;
         4'd14:   r = 4'hf;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   // High salt nibble ring
   function automatic nib_type high_ring_f(input nib_type i);
      nib_type r;
      case (i)
         4'd0:    r = 4'h0;
         4'd1:    r = 4'h6;
         4'd2:    r = 4'hf;
         4'd3:    r = 4'h8;
         4'd4:    r = 4'h7;
         4'd5:    r = 4'h5;
         4'd6:    r = 4'h3;
         4'd7:    r = 4'h4;
         4'd8:    r = 4'hc;
         4'd9:    r = 4'hd;
         4'd10:   r = 4'he;
         4'd11:   r = 4'h1;
         4'd12:   r = 4'h2;
         4'd13:   r = 4'hb;
         4'd14:   r = 4'ha;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   // Starting point in the ring for each high nibble of the run index
   function automatic nib_type high_start_f(input nib_type hi);
      nib_type r;
      case (hi)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd11;
         4'd2:    r = 4'd12;
         4'd3:    r = 4'd6;
         4'd4:    r = 4'd7;
         4'd5:    r = 4'd5;
         4'd6:    r = 4'd1;
         4'd7:    r = 4'd4;
         4'd8:    r = 4'd3;
         4'd9:    r = 4'd0;
         4'd10:   r = 4'd14;
         4'd11:   r = 4'd13;
         4'd12:   r = 4'd8;
         4'd13:   r = 4'd9;
         4'd14:   r = 4'd10;
         default: r = 4'd2;
      endcase
      return r;
   endfunction

   // Salt for a run index and an offset; zero past the end of the run
   function automatic byte_type salt_lookup_f(input byte_type idx, input nib_type off);
      nib_type            lo;
      nib_type            hi;
      nib_type            len;
      nib_type            hr;
      nib_type            lr_idx;
      logic [NIB_W:0]     ring_sum;
      byte_type           r;
      lo       = idx[NIB_W-1:0];
      hi       = idx[BYTE_W-1:NIB_W];
      len      = run_len_f(lo);
      ring_sum = {1'b0, high_start_f(hi)} + {1'b0, off};
      if (ring_sum >= (NIB_W+1)'(RING_LEN)) begin
         ring_sum = ring_sum - (NIB_W+1)'(RING_LEN);
      end
      if (hi == HIGH_NINE) begin
         hr = HIGH_NINE;
      end else begin
         hr = high_ring_f(ring_sum[NIB_W-1:0]);
      end
      // lr_idx is used only when off <= len, so the position stays within 0 to 14
      lr_idx = NIB_W'(RING_LEN - 1) + off - len;
      if (off > len) begin
         r = '0;
      end else begin
         r = {hr, low_nib_f(lr_idx)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/audio_quadlet_byte_scrambler.sv =====
// A result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: 1 quadlet per cycle while rsp_ready holds; the salt update for the next quadlet is a
//    table lookup done in the same cycle as the accept.
// The input is ready whenever the result register is empty or being drained.
// Synchronous active-high reset clears salt, run state, direction and rsp_valid.
`default_nettype none

module audio_quadlet_byte_scrambler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic                            csr_wr_data,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [aqbs_pkg::QUADLET_W-1:0]  req_quadlet_in,
   input  wire logic                            req_frame_start,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic [aqbs_pkg::QUADLET_W-1:0]  rsp_quadlet_out
);
   import aqbs_pkg::*;

   logic                  direction_ff;
   byte_type              salt_ff, salt_in;
   byte_type              index_ff, index_in;
   nib_type               offset_ff, offset_in;
   logic                  valid_ff, valid_in;
   logic [QUADLET_W-1:0]  quad_ff, quad_in;

   byte_type              salt_cur;
   byte_type              index_cur;
   nib_type               offset_cur;
   byte_type              in_byte;
   byte_type              plain;
   byte_type              scrambled;
   byte_type              out_byte;
   logic                  accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = !valid_ff || rsp_ready;

   // Clear the run on frame start, then scramble or unscramble the byte
   always_comb begin
      salt_cur   = req_frame_start ? '0 : salt_ff;
      index_cur  = req_frame_start ? '0 : index_ff;
      offset_cur = req_frame_start ? '0 : offset_ff;
      in_byte    = req_quadlet_in[15:8];
      if (!direction_ff) begin
         plain     = in_byte;
         scrambled = in_byte ^ salt_cur;
         out_byte  = scrambled;
      end else begin
         scrambled = in_byte;
         plain     = in_byte ^ salt_cur;
         out_byte  = plain;
      end
      // Restart the run on a nonzero plain byte
      if (plain != '0) begin
         index_in  = scrambled;
         offset_in = '0;
      end else begin
         index_in  = index_cur;
         offset_in = offset_cur;
      end
      // Advance the offset, holding at saturation
      if (offset_in != OFFSET_SAT) begin
         offset_in = offset_in + 1'b1;
      end
      salt_in = salt_lookup_f(index_in, offset_in);
      quad_in = {req_quadlet_in[31:16], out_byte, req_quadlet_in[7:0]};
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Hold run state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         salt_ff      <= '0;
         index_ff     <= '0;
         offset_ff    <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         if (accept) begin
            salt_ff   <= salt_in;
            index_ff  <= index_in;
            offset_ff <= offset_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         quad_ff <= quad_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_quadlet_out = quad_ff;

endmodule

`default_nettype wire

// ===== src/aqbs_checker.sv =====
`default_nettype none

module aqbs_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic [31:0]  req_quadlet_in,
   input wire logic         req_frame_start,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire logic [31:0]  rsp_quadlet_out
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quadlet_out))
      else $error("stalled result changed or dropped");

   // Every accepted transaction shows a result on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no result after accepted transaction");

   // Only bits 15:8 may change
   a_pass_bits: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=>
         rsp_quadlet_out[31:16] == $past(req_quadlet_in[31:16]) &&
         rsp_quadlet_out[7:0] == $past(req_quadlet_in[7:0]))
      else $error("bits outside the scrambled byte changed");

   // Frame start means zero salt, so the quadlet passes unchanged
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_start |=>
         rsp_quadlet_out == $past(req_quadlet_in))
      else $error("first quadlet of a frame was altered");

   // Empty output register never blocks the input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

endmodule

bind audio_quadlet_byte_scrambler aqbs_checker u_aqbs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_quadlet_in  (req_quadlet_in),
   .req_frame_start (req_frame_start),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_quadlet_out (rsp_quadlet_out)
);

`default_nettype wire
